### sv/upsc_pkg.sv
`default_nettype none

package upsc_pkg;

  localparam int PIXEL_BITS_DEF = 32;
  localparam int PIX_FIELD_W    = 32;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [1:0] SCALE_THREE = 2'd3;

  localparam logic [1:0] SEG_BORDER = 2'd1;
  localparam logic [1:0] SEG_TWO    = 2'd2;
  localparam logic [1:0] SEG_THREE  = 2'd3;

  localparam logic [1:0] REG_X_SCALE = 2'd0;
  localparam logic [1:0] REG_Y_SCALE = 2'd1;
  localparam logic [1:0] REG_BORDER  = 2'd2;

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_SEG,
    PH_TRAIL
  } phase_t;

  typedef struct packed {
    logic [1:0] x_scale;
    logic [1:0] y_scale;
    logic       border_enable;
  } cfg_t;

  typedef struct packed {
    logic lead;
    logic trail_first;
    logic second;
  } job_ctl_t;

  localparam int JOB_CTL_W = $bits(job_ctl_t);

endpackage

`default_nettype wire

### sv/upsc_front.sv
`default_nettype none

module upsc_front #(
  parameter int PIXEL_BITS = upsc_pkg::PIXEL_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [2:0][PIXEL_BITS-1:0]      in_col,
  input  logic                            in_end,
  output logic                            job_valid,
  input  logic                            job_ready,
  output logic [2:0][2:0][PIXEL_BITS-1:0] job_pix,
  output upsc_pkg::job_ctl_t              job_ctl
);
  import upsc_pkg::*;

  localparam logic [1:0] HELD_NONE = 2'd0;
  localparam logic [1:0] HELD_ONE  = 2'd1;
  localparam logic [1:0] HELD_TWO  = 2'd2;

  logic [1:0]                held;
  logic [1:0]                held_next;
  logic [2:0][PIXEL_BITS-1:0] prev_col;
  logic [2:0][PIXEL_BITS-1:0] cur_col;
  logic                      accept;

  assign in_ready = job_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    job_valid = 1'b0;
    job_pix[0] = prev_col;
    job_pix[1] = cur_col;
    job_pix[2] = in_col;
    job_ctl   = '0;
    held_next = held;
    case (held)
      HELD_NONE: begin
        job_valid = accept && in_end;
        job_pix[0] = in_col;
        job_pix[1] = in_col;
        job_ctl.lead = 1'b1;
        job_ctl.trail_first = 1'b1;
        held_next = in_end ? HELD_NONE : HELD_ONE;
      end
      HELD_ONE: begin
        job_valid = accept;
        job_pix[0] = cur_col;
        job_ctl.lead = 1'b1;
        job_ctl.second = in_end;
        held_next = in_end ? HELD_NONE : HELD_TWO;
      end
      default: begin
        job_valid = accept;
        job_ctl.second = in_end;
        held_next = in_end ? HELD_NONE : HELD_TWO;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= HELD_NONE;
    end else if (accept) begin
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (held != HELD_NONE) begin
        prev_col <= cur_col;
      end
      cur_col <= in_col;
    end
  end

endmodule

`default_nettype wire

### sv/upsc_queue.sv
`default_nettype none

module upsc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = upsc_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);
  import upsc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DEPTH-1:0][WIDTH-1:0] slots;
  logic [PTR_W-1:0]            wr_ptr;
  logic [PTR_W-1:0]            rd_ptr;
  logic [CNT_W-1:0]            count;
  logic                        push;
  logic                        pop;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_data;
    end
  end

endmodule

`default_nettype wire

### sv/upsc_back.sv
`default_nettype none

module upsc_back #(
  parameter int PIXEL_BITS = upsc_pkg::PIXEL_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  upsc_pkg::cfg_t                        cfg,
  input  logic                                  job_valid,
  output logic                                  job_pop,
  input  logic [2:0][2:0][PIXEL_BITS-1:0]       job_pix,
  input  upsc_pkg::job_ctl_t                    job_ctl,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [1:0]                            out_row,
  output logic [upsc_pkg::PIX_FIELD_W-1:0]      seg_pixel0,
  output logic [upsc_pkg::PIX_FIELD_W-1:0]      seg_pixel1,
  output logic [upsc_pkg::PIX_FIELD_W-1:0]      seg_pixel2,
  output logic [1:0]                            seg_count,
  output logic                                  run_last
);
  import upsc_pkg::*;

  phase_t                     phase;
  phase_t                     phase_next;
  phase_t                     eff;
  logic                       col;
  logic                       col_next;
  logic [1:0]                 row;
  logic [1:0]                 row_next;
  logic [1:0]                 rows_m1;
  logic                       x3;
  logic                       lead_here;
  logic                       trail_here;
  logic                       row_done;
  logic                       last_step;
  logic                       adv;
  logic                       sw;
  logic [2:0][PIXEL_BITS-1:0] lc;
  logic [2:0][PIXEL_BITS-1:0] mc;
  logic [2:0][PIXEL_BITS-1:0] rc;
  logic [PIXEL_BITS-1:0]      u;
  logic [PIXEL_BITS-1:0]      d;
  logic [PIXEL_BITS-1:0]      c;
  logic [PIXEL_BITS-1:0]      l;
  logic [PIXEL_BITS-1:0]      r;
  logic [PIXEL_BITS-1:0]      ul;
  logic [PIXEL_BITS-1:0]      ur;
  logic [PIXEL_BITS-1:0]      ep0;
  logic [PIXEL_BITS-1:0]      ep1;
  logic [PIXEL_BITS-1:0]      ep2;
  logic [PIXEL_BITS-1:0]      cq0;
  logic [PIXEL_BITS-1:0]      cq1;
  logic [PIXEL_BITS-1:0]      p0;
  logic [PIXEL_BITS-1:0]      p1;
  logic [PIXEL_BITS-1:0]      p2;

  assign x3      = (cfg.x_scale == SCALE_THREE);
  assign rows_m1 = (cfg.y_scale == SCALE_THREE) ? 2'd2 : 2'd1;

  // The second column of a job is the last column of the row, seen with its
  // right neighbor replicated.
  assign lc = col ? job_pix[1] : job_pix[0];
  assign mc = col ? job_pix[2] : job_pix[1];
  assign rc = job_pix[2];

  assign lead_here  = cfg.border_enable && job_ctl.lead && !col;
  assign trail_here = cfg.border_enable && (col || job_ctl.trail_first);
  assign eff        = (phase == PH_LEAD && !lead_here) ? PH_SEG : phase;

  always_comb begin
    sw = (row != 2'd0);
    u  = sw ? mc[2] : mc[0];
    d  = sw ? mc[0] : mc[2];
    c  = mc[1];
    l  = lc[1];
    r  = rc[1];
    ul = sw ? lc[2] : lc[0];
    ur = sw ? rc[2] : rc[0];

    ep0 = c;
    ep1 = c;
    ep2 = '0;
    if (x3) begin
      ep2 = c;
      if (u != d && l != r) begin
        ep0 = (l == u) ? l : c;
        ep1 = ((l == u && c != ur) || (r == u && c != ul)) ? u : c;
        ep2 = (r == u) ? r : c;
      end
    end else begin
      ep0 = (l == u && d != u && r != u) ? u : c;
      ep1 = (r == u && d != u && l != u) ? u : c;
    end

    cq0 = c;
    cq1 = c;
    if (mc[0] != mc[2] && l != r) begin
      cq0 = ((l == mc[0] && c != lc[2]) || (l == mc[2] && c != lc[0])) ? l : c;
      cq1 = ((r == mc[0] && c != rc[2]) || (r == mc[2] && c != rc[0])) ? r : c;
    end

    if (row == 2'd0 || row >= rows_m1) begin
      p0 = ep0;
      p1 = ep1;
      p2 = ep2;
    end else if (x3) begin
      p0 = cq0;
      p1 = c;
      p2 = cq1;
    end else begin
      p0 = cq0;
      p1 = cq1;
      p2 = '0;
    end
  end

  always_comb begin
    phase_next = phase;
    row_next   = row;
    col_next   = col;
    row_done   = 1'b0;
    last_step  = 1'b0;
    case (eff)
      PH_LEAD:  phase_next = PH_SEG;
      PH_SEG: begin
        if (trail_here) begin
          phase_next = PH_TRAIL;
        end else begin
          row_done = 1'b1;
        end
      end
      PH_TRAIL: row_done = 1'b1;
      default:  row_done = 1'b1;
    endcase
    if (row_done) begin
      phase_next = PH_LEAD;
      if (row >= rows_m1) begin
        row_next = 2'd0;
        if (!col && job_ctl.second) begin
          col_next = 1'b1;
        end else begin
          col_next  = 1'b0;
          last_step = 1'b1;
        end
      end else begin
        row_next = row + 2'd1;
      end
    end
  end

  assign adv     = job_valid && (!out_valid || out_ready);
  assign job_pop = adv && last_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_LEAD;
      row   <= 2'd0;
      col   <= 1'b0;
    end else if (adv) begin
      phase <= phase_next;
      row   <= row_next;
      col   <= col_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_row  <= row;
      run_last <= last_step;
      if (eff == PH_SEG) begin
        seg_pixel0 <= PIX_FIELD_W'(p0);
        seg_pixel1 <= PIX_FIELD_W'(p1);
        seg_pixel2 <= PIX_FIELD_W'(p2);
        seg_count  <= x3 ? SEG_THREE : SEG_TWO;
      end else begin
        seg_pixel0 <= '0;
        seg_pixel1 <= '0;
        seg_pixel2 <= '0;
        seg_count  <= SEG_BORDER;
      end
    end
  end

endmodule

`default_nettype wire

### sv/scale2x_scale3x_pixel_upscaler_top.sv
// Channel  Direction  Handshake              Payload
// s_axis   in         s_axis_tvalid/tready   tdata: above, center, below; tlast: row end
// m_axis   out        m_axis_tvalid/tready   tdata: pixel0..2, count; tuser: row; tlast
// apb      in         psel/penable/pready    x_scale @0x0, y_scale @0x4, border_enable @0x8
//
// The output side delivers one result per cycle while a job is queued and m_axis does not stall; a column item
// yields 0 to 12 results, two to nine for each column that the scaling sequencer expands.
// The first column of a longer row yields nothing until its right neighbor arrives.
// A two-entry column queue lets the input side take items while the sequencer works.
// Reset clears the window count, the queue and the sequencer; no clearing pass is needed.
// A stall on m_axis holds the output register, then fills the queue, then drops s_axis_tready.
`default_nettype none

module scale2x_scale3x_pixel_upscaler_top #(
  parameter int PIXEL_BITS = upsc_pkg::PIXEL_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // pixel_above, pixel_center, pixel_below
  input  logic         s_axis_tlast,   // row_end
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,   // seg_pixel0, seg_pixel1, seg_pixel2, seg_count
  output logic [1:0]   m_axis_tuser,   // out_row
  output logic         m_axis_tlast,   // run_last
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import upsc_pkg::*;

  localparam int JOB_W = 9 * PIXEL_BITS + JOB_CTL_W;

  cfg_t                            cfg;
  logic [1:0]                      x_scale;
  logic [1:0]                      y_scale;
  logic                            border_enable;
  logic                            cfg_write;
  logic [2:0][PIXEL_BITS-1:0]      in_col;
  logic                            f_valid;
  logic                            f_ready;
  logic [2:0][2:0][PIXEL_BITS-1:0] f_pix;
  job_ctl_t                        f_ctl;
  logic                            b_valid;
  logic                            b_pop;
  logic [2:0][2:0][PIXEL_BITS-1:0] b_pix;
  job_ctl_t                        b_ctl;
  logic [JOB_W-1:0]                q_in;
  logic [JOB_W-1:0]                q_out;
  logic [1:0]                      seg_count;
  logic [PIX_FIELD_W-1:0]          seg_pixel0;
  logic [PIX_FIELD_W-1:0]          seg_pixel1;
  logic [PIX_FIELD_W-1:0]          seg_pixel2;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_scale       <= 2'd2;
      y_scale       <= 2'd2;
      border_enable <= 1'b0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_X_SCALE: x_scale       <= pwdata[1:0];
        REG_Y_SCALE: y_scale       <= pwdata[1:0];
        REG_BORDER:  border_enable <= pwdata[0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_X_SCALE: prdata = {30'd0, x_scale};
      REG_Y_SCALE: prdata = {30'd0, y_scale};
      REG_BORDER:  prdata = {31'd0, border_enable};
      default:     prdata = 32'd0;
    endcase
  end

  assign cfg.x_scale       = x_scale;
  assign cfg.y_scale       = y_scale;
  assign cfg.border_enable = border_enable;

  assign in_col[0] = s_axis_tdata[0 +: PIXEL_BITS];
  assign in_col[1] = s_axis_tdata[PIX_FIELD_W +: PIXEL_BITS];
  assign in_col[2] = s_axis_tdata[2*PIX_FIELD_W +: PIXEL_BITS];

  upsc_front #(
    .PIXEL_BITS(PIXEL_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_col    (in_col),
    .in_end    (s_axis_tlast),
    .job_valid (f_valid),
    .job_ready (f_ready),
    .job_pix   (f_pix),
    .job_ctl   (f_ctl)
  );

  assign q_in = {f_ctl, f_pix};

  upsc_queue #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (q_in),
    .out_valid (b_valid),
    .out_ready (b_pop),
    .out_data  (q_out)
  );

  assign {b_ctl, b_pix} = q_out;

  upsc_back #(
    .PIXEL_BITS(PIXEL_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .job_valid  (b_valid),
    .job_pop    (b_pop),
    .job_pix    (b_pix),
    .job_ctl    (b_ctl),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_row    (m_axis_tuser),
    .seg_pixel0 (seg_pixel0),
    .seg_pixel1 (seg_pixel1),
    .seg_pixel2 (seg_pixel2),
    .seg_count  (seg_count),
    .run_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, seg_count, seg_pixel2, seg_pixel1, seg_pixel0};

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && seg_count != SEG_BORDER |->
      seg_count == ((x_scale == SCALE_THREE) ? SEG_THREE : SEG_TWO))
    else $error("segment width does not follow the horizontal factor");

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tuser != 2'd3 &&
      (y_scale == SCALE_THREE || m_axis_tuser != 2'd2))
    else $error("output row beyond the vertical factor");

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && seg_count == SEG_BORDER |->
      border_enable && seg_pixel0 == '0 && seg_pixel1 == '0 && seg_pixel2 == '0)
    else $error("border item without border enabled or with nonzero pixels");

endmodule

`default_nettype wire

### verif/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import upsc_pkg::*;

  localparam int STALL_CYCLES = 160;
  localparam int DRAIN_CYCLES = 20;

  typedef logic [31:0] pix_t;

  typedef struct packed {
    pix_t below;
    pix_t center;
    pix_t above;
  } column_t;

  typedef struct packed {
    logic    row_end;
    column_t col;
  } column_item_t;

  typedef struct packed {
    logic [1:0] row;
    pix_t       p0;
    pix_t       p1;
    pix_t       p2;
    logic [1:0] count;
    logic       last;
  } segment_t;

  typedef struct packed {
    pix_t p2;
    pix_t p1;
    pix_t p0;
  } triple_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata = '0;   // pixel_above, pixel_center, pixel_below
  logic         s_axis_tlast = 1'b0; // row_end
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;        // seg_pixel0, seg_pixel1, seg_pixel2, seg_count
  logic [1:0]   m_axis_tuser;        // out_row
  logic         m_axis_tlast;        // run_last
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  scale2x_scale3x_pixel_upscaler_top DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  column_item_t columns_todo[$];
  segment_t     segments_due[$];
  column_item_t offer = '0;

  logic [1:0] cfg_x = 2'd2;
  logic [1:0] cfg_y = 2'd2;
  logic       cfg_border = 1'b0;
  column_t    win_prev = '0;
  column_t    win_cur = '0;
  int         cols_held = 0;

  int   src_idle = 0;
  int   sink_idle = 0;
  logic stall_arm = 1'b0;
  logic stall_done = 1'b0;
  int   stall_left = 0;

  int   errors = 0;
  int   columns_sent = 0;
  int   segments_checked = 0;
  int   settings_used = 1;
  pix_t palette[3];

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  function automatic triple_t edge_triple(column_t lc, column_t mc, column_t rc, logic swap);
    pix_t u, d, c, l, r, ul, ur;
    triple_t t;
    u  = swap ? mc.below : mc.above;
    d  = swap ? mc.above : mc.below;
    c  = mc.center;
    l  = lc.center;
    r  = rc.center;
    ul = swap ? lc.below : lc.above;
    ur = swap ? rc.below : rc.above;
    t.p0 = c;
    t.p1 = c;
    t.p2 = '0;
    if (cfg_x == SCALE_THREE) begin
      t.p2 = c;
      if (u != d && l != r) begin
        t.p0 = (l == u) ? l : c;
        t.p1 = ((l == u && c != ur) || (r == u && c != ul)) ? u : c;
        t.p2 = (r == u) ? r : c;
      end
    end else begin
      t.p0 = (l == u && d != u && r != u) ? u : c;
      t.p1 = (r == u && d != u && l != u) ? u : c;
    end
    return t;
  endfunction

  function automatic triple_t middle_triple(column_t lc, column_t mc, column_t rc);
    pix_t u, d, c, l, r, q0, q1;
    triple_t t;
    u  = mc.above;
    d  = mc.below;
    c  = mc.center;
    l  = lc.center;
    r  = rc.center;
    q0 = c;
    q1 = c;
    if (u != d && l != r) begin
      q0 = ((l == u && c != lc.below) || (l == d && c != lc.above)) ? l : c;
      q1 = ((r == u && c != rc.below) || (r == d && c != rc.above)) ? r : c;
    end
    if (cfg_x == SCALE_THREE) begin
      t.p0 = q0;
      t.p1 = c;
      t.p2 = q1;
    end else begin
      t.p0 = q0;
      t.p1 = q1;
      t.p2 = '0;
    end
    return t;
  endfunction

  task automatic push_border(int r);
    segment_t s;
    s = '{row: 2'(r), p0: '0, p1: '0, p2: '0, count: SEG_BORDER, last: 1'b0};
    segments_due.push_back(s);
  endtask

  task automatic expand_column(column_t lc, column_t mc, column_t rc, logic lead, logic trail);
    int rows;
    logic [1:0] cnt;
    triple_t t;
    segment_t s;
    rows = (cfg_y == SCALE_THREE) ? 3 : 2;
    cnt = (cfg_x == SCALE_THREE) ? SEG_THREE : SEG_TWO;
    for (int r = 0; r < rows; r++) begin
      if (lead && cfg_border) push_border(r);
      if (r == 0) t = edge_triple(lc, mc, rc, 1'b0);
      else if (r == rows - 1) t = edge_triple(lc, mc, rc, 1'b1);
      else t = middle_triple(lc, mc, rc);
      s = '{row: 2'(r), p0: t.p0, p1: t.p1, p2: t.p2, count: cnt, last: 1'b0};
      segments_due.push_back(s);
      if (trail && cfg_border) push_border(r);
    end
  endtask

  task automatic predict_column(column_item_t it);
    int n_before;
    column_t old_cur;
    segment_t s;
    n_before = segments_due.size();
    old_cur = win_cur;
    if (cols_held == 0) begin
      if (it.row_end) begin
        expand_column(it.col, it.col, it.col, 1'b1, 1'b1);
      end else begin
        win_cur = it.col;
        cols_held = 1;
      end
    end else begin
      if (cols_held == 1) expand_column(old_cur, old_cur, it.col, 1'b1, 1'b0);
      else expand_column(win_prev, old_cur, it.col, 1'b0, 1'b0);
      win_prev = old_cur;
      win_cur = it.col;
      if (it.row_end) begin
        expand_column(old_cur, it.col, it.col, 1'b0, 1'b1);
        cols_held = 0;
      end else begin
        cols_held = 2;
      end
    end
    if (segments_due.size() > n_before) begin
      s = segments_due.pop_back();
      s.last = 1'b1;
      segments_due.push_back(s);
    end
  endtask

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
  endtask

  always @(posedge clk) begin
    logic next_valid;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      next_valid = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_column(offer);
        columns_sent++;
        next_valid = 1'b0;
      end
      if (!next_valid && columns_todo.size() != 0 && $urandom_range(0, 99) >= src_idle) begin
        offer = columns_todo.pop_front();
        next_valid = 1'b1;
      end
      s_axis_tvalid <= next_valid;
      s_axis_tdata <= offer.col;
      s_axis_tlast <= offer.row_end;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      stall_left <= 0;
      stall_done <= 1'b0;
    end else if (stall_arm && !stall_done) begin
      stall_left <= STALL_CYCLES;
      stall_done <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk) begin
    segment_t got;
    segment_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{row: m_axis_tuser, p0: m_axis_tdata[31:0], p1: m_axis_tdata[63:32],
                p2: m_axis_tdata[95:64], count: m_axis_tdata[97:96], last: m_axis_tlast};
        if (segments_due.size() == 0) begin
          report_mismatch("result arrived with no segment expected");
        end else begin
          want = segments_due.pop_front();
          check_field("out_row", 32'(got.row), 32'(want.row));
          check_field("seg_pixel0", got.p0, want.p0);
          check_field("seg_pixel1", got.p1, want.p1);
          check_field("seg_pixel2", got.p2, want.p2);
          check_field("seg_count", 32'(got.count), 32'(want.count));
          check_field("run_last", 32'(got.last), 32'(want.last));
          segments_checked++;
        end
      end
      m_axis_tready <= (stall_left == 0) && ($urandom_range(0, 99) >= sink_idle);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_X_SCALE: cfg_x = data[1:0];
      REG_Y_SCALE: cfg_y = data[1:0];
      REG_BORDER:  cfg_border = data[0];
      default: ;
    endcase
  endtask

  task automatic apply_config(logic [1:0] xs, logic [1:0] ys, logic be);
    write_reg(REG_X_SCALE, {30'd0, xs});
    write_reg(REG_Y_SCALE, {30'd0, ys});
    write_reg(REG_BORDER, {31'd0, be});
    settings_used++;
  endtask

  task automatic wait_drained();
    while (columns_todo.size() != 0 || s_axis_tvalid || segments_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic queue_column(pix_t a, pix_t c, pix_t b, logic last_col);
    column_item_t it;
    it.col.above = a;
    it.col.center = c;
    it.col.below = b;
    it.row_end = last_col;
    columns_todo.push_back(it);
  endtask

  function automatic pix_t pick_pixel();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return '1;
      2: return $urandom;
      default: return palette[$urandom_range(0, 2)];
    endcase
  endfunction

  task automatic queue_row(int width);
    for (int i = 0; i < 3; i++) begin
      if ($urandom_range(0, 2) == 0) palette[i] = $urandom;
    end
    for (int c = 0; c < width; c++)
      queue_column(pick_pixel(), pick_pixel(), pick_pixel(), c == width - 1);
  endtask

  task automatic random_phase(int n_items);
    int count;
    int width;
    count = 0;
    while (count < n_items) begin
      width = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 6);
      queue_row(width);
      count += width;
    end
  endtask

  initial begin
    pix_t pa, pb;
    for (int i = 0; i < 3; i++) palette[i] = $urandom;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    src_idle = 9;
    sink_idle = 54;

    pa = $urandom;
    pb = ~pa;
    queue_column('0, '0, '0, 1'b1);
    queue_column('1, '1, '1, 1'b1);
    queue_column('0, '1, '0, 1'b0);
    queue_column('1, '0, '1, 1'b1);
    queue_column(pa, pa, pb, 1'b0);
    queue_column(pa, pb, pb, 1'b0);
    queue_column(pb, pb, pa, 1'b1);
    wait_drained();

    apply_config(2'd3, 2'd3, 1'b1);
    queue_column(pa, pb, '1, 1'b1);
    queue_column(pa, pa, pb, 1'b0);
    queue_column(pa, pb, pb, 1'b0);
    queue_column(pb, pb, pa, 1'b1);
    queue_column(pb, pa, pa, 1'b0);
    queue_column(pb, pb, pa, 1'b0);
    queue_column(pa, pa, pb, 1'b0);
    queue_column(pa, pb, pb, 1'b1);
    wait_drained();

    apply_config(2'd0, 2'd1, 1'b0);
    random_phase(15);
    wait_drained();
    apply_config(2'd3, 2'd2, 1'b1);
    random_phase(15);
    wait_drained();

    src_idle = 54;
    sink_idle = 9;
    apply_config(2'd2, 2'd3, 1'b0);
    random_phase(15);
    wait_drained();
    apply_config(2'd1, 2'd0, 1'b1);
    random_phase(15);
    wait_drained();

    src_idle = 0;
    sink_idle = 0;
    apply_config(2'd3, 2'd3, 1'b1);
    random_phase(16);
    stall_arm = 1'b1;
    wait_drained();
    apply_config(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    random_phase(15);
    wait_drained();

    if (segments_due.size() != 0)
      report_mismatch($sformatf("%0d segments never arrived", segments_due.size()));
    $display("summary: %0d columns sent, %0d segments checked, %0d register settings,",
             columns_sent, segments_checked, settings_used);
    $display("summary: idle mixes on both sides and one long output stall");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
